// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the bounded deque with search
// Operation codes, the classified command word and the back-end states.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned FuncWidth  = 3;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned CmdDepth   = 2;

  // operation codes as they arrive on the func field
  typedef enum logic [FuncWidth-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_NOP        = 3'd7
  } op_e;

  // classified command handed from front end to back end
  typedef struct packed {
    op_e                          op;
    logic signed [WordWidth-1:0]  value;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_FRONT,
    ST_FILL_REAR,
    ST_SCAN,
    ST_OUT
  } back_state_e;

  localparam logic signed [WordWidth-1:0] EmptyWord = '1;

  // unknown codes become a no-operation
  function automatic op_e classify(input logic [FuncWidth-1:0] func);
    op_e op;
    case (func)
      OP_PUSH_BACK:  op = OP_PUSH_BACK;
      OP_PUSH_FRONT: op = OP_PUSH_FRONT;
      OP_POP_FRONT:  op = OP_POP_FRONT;
      OP_POP_BACK:   op = OP_POP_BACK;
      OP_SEARCH:     op = OP_SEARCH;
      default:       op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ----- hw/rtl/dq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_front: input stage of the deque
// Accepts items, classifies the operation code and holds one command until
// the command queue takes it.
// ----------------------------------------------------------------------------
module dq_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dq_pkg::FuncWidth-1:0]          func_i,
  input  logic signed [dq_pkg::WordWidth-1:0]   value_i,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_ready_i,
  output dq_pkg::cmd_t                          cmd_o
);

  logic         vld_q, vld_d;
  dq_pkg::cmd_t cmd_q;
  logic         in_xfer;

  // stage is free when empty or draining this cycle
  assign in_ready_o = !vld_q || cmd_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (in_xfer) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // classified command payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q.op    <= dq_pkg::classify(func_i);
      cmd_q.value <= value_i;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

// ----- hw/rtl/dq_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cmd_fifo: short command queue between front and back end
// Lets the input side keep taking items while the back end is busy.
// ----------------------------------------------------------------------------
module dq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  dq_pkg::cmd_t  wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output dq_pkg::cmd_t  rd_cmd_o
);

  localparam int unsigned PtrWidth = $clog2(dq_pkg::CmdDepth);
  localparam int unsigned CntWidth = $clog2(dq_pkg::CmdDepth + 1);

  dq_pkg::cmd_t         slot_q [dq_pkg::CmdDepth];
  logic [PtrWidth-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 wr_xfer, rd_xfer;

  assign wr_ready_o = (cnt_q != CntWidth'(dq_pkg::CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_xfer    = wr_valid_i && wr_ready_o;
  assign rd_xfer    = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = slot_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_xfer) begin
      wptr_d = (wptr_q == PtrWidth'(dq_pkg::CmdDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_xfer) begin
      rptr_d = (rptr_q == PtrWidth'(dq_pkg::CmdDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_xfer && !rd_xfer) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_xfer && !wr_xfer) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (wr_xfer) begin
      slot_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ----- hw/rtl/dq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_back: deque execution unit
// Holds the ring memory, head and tail pointers and the count, carries out
// one command at a time and keeps the result in registers until taken.
// ----------------------------------------------------------------------------
module dq_back #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  output logic                                  cmd_ready_o,
  input  dq_pkg::cmd_t                          cmd_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  found_o,
  output logic                                  refused_o,
  output logic                                  is_empty_o,
  output logic signed [dq_pkg::WordWidth-1:0]   front_value_o,
  output logic signed [dq_pkg::WordWidth-1:0]   rear_value_o,
  output logic [dq_pkg::CountWidth-1:0]         entry_count_o
);

  localparam int unsigned IdxWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(CAPACITY - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(CAPACITY);

  dq_pkg::back_state_e          state_q, state_d;
  logic [IdxWidth-1:0]          head_q, head_d, tail_q, tail_d;
  logic [CntWidth-1:0]          cnt_q, cnt_d;
  logic signed [dq_pkg::WordWidth-1:0] front_q, front_d, rear_q, rear_d;
  logic signed [dq_pkg::WordWidth-1:0] key_q, key_d;
  logic                         found_q, found_d, refused_q, refused_d;
  logic [IdxWidth-1:0]          scan_ptr_q, scan_ptr_d;
  logic [CntWidth-1:0]          scan_left_q, scan_left_d;
  logic                         rd_vld_q, rd_vld_d;

  // ring memory ports
  logic signed [dq_pkg::WordWidth-1:0] ring_mem [CAPACITY];
  logic signed [dq_pkg::WordWidth-1:0] rd_data_q;
  logic                         mem_we, mem_re;
  logic [IdxWidth-1:0]          mem_waddr, mem_raddr;
  logic signed [dq_pkg::WordWidth-1:0] mem_wdata;

  logic                         is_full, is_empty;
  logic [IdxWidth-1:0]          head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

  function automatic logic [IdxWidth-1:0] wrap_inc(input logic [IdxWidth-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxWidth-1:0] wrap_dec(input logic [IdxWidth-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  assign is_full   = (cnt_q == FullCnt);
  assign is_empty  = (cnt_q == '0);
  assign head_inc  = wrap_inc(head_q);
  assign head_dec  = wrap_dec(head_q);
  assign tail_inc  = wrap_inc(tail_q);
  assign tail_dec  = wrap_dec(tail_q);
  assign tail_dec2 = wrap_dec(tail_dec);

  // sequencer: next state, pointer updates and memory control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    rear_d      = rear_q;
    key_d       = key_q;
    found_d     = found_q;
    refused_d   = refused_q;
    scan_ptr_d  = scan_ptr_q;
    scan_left_d = scan_left_q;
    rd_vld_d    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = tail_q;
    mem_raddr   = scan_ptr_q;
    mem_wdata   = cmd_i.value;
    cmd_ready_o = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      dq_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          found_d   = 1'b0;
          refused_d = 1'b0;
          state_d   = dq_pkg::ST_OUT;
          case (cmd_i.op)
            dq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                refused_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                tail_d    = tail_inc;
                cnt_d     = cnt_q + 1'b1;
                rear_d    = cmd_i.value;
                if (is_empty) begin
                  front_d = cmd_i.value;
                end
              end
            end
            dq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                refused_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_d    = head_dec;
                cnt_d     = cnt_q + 1'b1;
                front_d   = cmd_i.value;
                if (is_empty) begin
                  rear_d = cmd_i.value;
                end
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                refused_d = 1'b1;
              end else begin
                head_d = head_inc;
                cnt_d  = cnt_q - 1'b1;
                if (cnt_q == CntWidth'(1)) begin
                  front_d = dq_pkg::EmptyWord;
                  rear_d  = dq_pkg::EmptyWord;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = head_inc;
                  state_d   = dq_pkg::ST_FILL_FRONT;
                end
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                refused_d = 1'b1;
              end else begin
                tail_d = tail_dec;
                cnt_d  = cnt_q - 1'b1;
                if (cnt_q == CntWidth'(1)) begin
                  front_d = dq_pkg::EmptyWord;
                  rear_d  = dq_pkg::EmptyWord;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = tail_dec2;
                  state_d   = dq_pkg::ST_FILL_REAR;
                end
              end
            end
            dq_pkg::OP_SEARCH: begin
              key_d       = cmd_i.value;
              scan_ptr_d  = head_q;
              scan_left_d = cnt_q;
              if (!is_empty) begin
                state_d = dq_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // new end value arrives from the memory read
      dq_pkg::ST_FILL_FRONT: begin
        front_d = rd_data_q;
        state_d = dq_pkg::ST_OUT;
      end

      dq_pkg::ST_FILL_REAR: begin
        rear_d  = rd_data_q;
        state_d = dq_pkg::ST_OUT;
      end

      // one read issued and one compare made per cycle
      dq_pkg::ST_SCAN: begin
        if (rd_vld_q && (rd_data_q == key_q)) begin
          found_d = 1'b1;
          state_d = dq_pkg::ST_OUT;
        end else if (scan_left_q != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_ptr_q;
          scan_ptr_d  = wrap_inc(scan_ptr_q);
          scan_left_d = scan_left_q - 1'b1;
          rd_vld_d    = 1'b1;
        end else begin
          state_d = dq_pkg::ST_OUT;
        end
      end

      dq_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = dq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dq_pkg::ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      front_q  <= dq_pkg::EmptyWord;
      rear_q   <= dq_pkg::EmptyWord;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      front_q  <= front_d;
      rear_q   <= rear_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // search and result payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    found_q     <= found_d;
    refused_q   <= refused_d;
    scan_ptr_q  <= scan_ptr_d;
    scan_left_q <= scan_left_d;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[mem_raddr];
    end
  end

  // result ports come straight from registers; is_empty is decoded from the count
  assign found_o       = found_q;
  assign refused_o     = refused_q;
  assign is_empty_o    = is_empty;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign entry_count_o = dq_pkg::CountWidth'(cnt_q);

endmodule

// ----- hw/rtl/bounded_deque_with_search_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit: ring-buffer deque with value search
// Input channel (in_valid_i/in_ready_o, func_i, value_i) takes one operation
// per transfer: push back, push front, pop front, pop back or search; other
// codes leave the queue as it is. Output channel (out_valid_o/out_ready_i)
// returns one result per item: found, refused, is_empty, front and rear
// values (-1 when empty) and the entry count after the operation.
// Each item passes the input register, a command queue slot and the
// sequencer; a pop that refetches an end value also waits for a memory
// read, and a search walks the entries from the head and ends early on
// a hit. Result valid is raised in the sequencer's output state.
// The execution unit works on one item at a time; the single read port
// of the ring memory paces the refetches and the scan, which walks one
// entry a cycle. The input stage and a two-entry command queue keep
// accepting items while the execution unit is busy or its result waits.
// Reset empties the queue (head, tail and count cleared); ring contents are
// left as they are. When the receiver stalls, the result holds on the ports
// and the execution unit waits; input is taken until the queue fills.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dq_pkg::FuncWidth-1:0]          func_i,
  input  logic signed [dq_pkg::WordWidth-1:0]   value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  found_o,
  output logic                                  refused_o,
  output logic                                  is_empty_o,
  output logic signed [dq_pkg::WordWidth-1:0]   front_value_o,
  output logic signed [dq_pkg::WordWidth-1:0]   rear_value_o,
  output logic [dq_pkg::CountWidth-1:0]         entry_count_o
);

  logic         fe_valid, fe_ready;
  dq_pkg::cmd_t fe_cmd;
  logic         be_valid, be_ready;
  dq_pkg::cmd_t be_cmd;

  // input stage and operation decode
  dq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  // command queue between the two halves
  dq_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_cmd_i   (fe_cmd),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready),
    .rd_cmd_o   (be_cmd)
  );

  // execution unit with ring memory
  dq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (be_valid),
    .cmd_ready_o   (be_ready),
    .cmd_i         (be_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .refused_o     (refused_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .entry_count_o (entry_count_o)
  );

endmodule
